@@ design/rgbe_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbe_pkg
// Shared types and codes for the RGBE scanline run-length decoder.
// ----------------------------------------------------------------------------
package rgbe_pkg;

   // Decoder phase within a scanline
   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,   // first 4-byte group of a line
      PH_OLD     = 3'd1,   // old-format pixels and repeat markers
      PH_CODE    = 3'd2,   // new-format run or literal code byte
      PH_RUNVAL  = 3'd3,   // new-format run value byte
      PH_LITERAL = 3'd4    // new-format literal bytes
   } phase_type;

   // Error codes on the result channel
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_LENGTH  = 2'd1;
   localparam logic [1:0] ERR_OVERRUN = 2'd2;
   localparam logic [1:0] ERR_EOS     = 2'd3;

   // Channel codes on the result channel
   localparam logic [2:0] CH_RED      = 3'd0;
   localparam logic [2:0] CH_GREEN    = 3'd1;
   localparam logic [2:0] CH_BLUE     = 3'd2;
   localparam logic [2:0] CH_EXPONENT = 3'd3;
   localparam logic [2:0] CH_PIXEL    = 3'd4;

   // Repeat shift steps (shift = 8 * step), saturating at 24
   localparam logic [1:0] SHIFT_MAX   = 2'd3;

   // Marker bytes
   localparam logic [7:0] HDR_BYTE    = 8'd2;
   localparam logic [7:0] REP_BYTE    = 8'd1;
   localparam logic [7:0] RUN_LIMIT   = 8'd128;

   localparam logic [14:0] RESET_LENGTH = 15'd1024;
   localparam logic [14:0] MIN_NEW_LENGTH = 15'd8;

   // One result item
   typedef struct packed {
      logic [14:0] run_start;
      logic [14:0] run_count;
      logic [2:0]  channel;
      logic [7:0]  red_value;
      logic [7:0]  green_value;
      logic [7:0]  blue_value;
      logic [7:0]  exponent_value;
      logic        line_done;
      logic [1:0]  error_code;
   } rsp_type;

   // One request item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_ended;
   } req_type;

endpackage

@@ design/rgbe_in_reg.sv @@
// ----------------------------------------------------------------------------
// rgbe_in_reg
// Input register: holds one request until the decode step takes it.
// ----------------------------------------------------------------------------
module rgbe_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rgbe_pkg::req_type req_data,
   input  logic              take,
   output logic              held_valid,
   output rgbe_pkg::req_type held_data
);

   logic              valid_ff;
   logic              valid_in;
   rgbe_pkg::req_type data_ff;

   // Accept when empty or when the held request leaves this cycle
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on accept
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign held_valid = valid_ff;
   assign held_data  = data_ff;

endmodule

@@ design/rgbe_decode.sv @@
// ----------------------------------------------------------------------------
// rgbe_decode
// Scanline decode state and the single-step byte decoder.
// ----------------------------------------------------------------------------
module rgbe_decode #(
   parameter int MAX_LINE_LENGTH = 32767
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [14:0]       csr_length,
   input  logic              step,
   input  rgbe_pkg::req_type item,
   output logic              res_valid,
   output rgbe_pkg::rsp_type res
);

   // State registers
   rgbe_pkg::phase_type phase_ff, phase_in;
   logic [14:0] length_ff, length_in;
   logic [14:0] column_ff, column_in;
   logic [1:0]  chan_ff, chan_in;
   logic [23:0] gathered_ff, gathered_in;
   logic [1:0]  pos_ff, pos_in;
   logic [31:0] prev_ff, prev_in;
   logic [7:0]  pending_ff, pending_in;
   logic [1:0]  shift_ff, shift_in;

   // Step working values
   logic [7:0]  byte_val;
   logic [7:0]  r_byte, g_byte, b_byte;
   logic [31:0] px;
   logic [14:0] rem;
   logic        over;
   logic [14:0] rep_count;
   logic [15:0] col_ext;
   logic [15:0] sum_code;
   logic [15:0] sum_pend;
   logic        new_header;
   logic [2:0]  fail_ch;
   logic        fail_en;
   logic [1:0]  fail_code;
   logic        wp_en;
   logic [14:0] wp_count;
   logic [31:0] wp_px;
   logic [15:0] wp_sum;
   logic        cr_en;
   logic [7:0]  cr_count;
   logic [7:0]  cr_val;
   logic [15:0] cr_sum;
   logic        restart;

   assign byte_val = item.data_byte;
   assign r_byte   = gathered_ff[7:0];
   assign g_byte   = gathered_ff[15:8];
   assign b_byte   = gathered_ff[23:16];
   assign px       = {byte_val, gathered_ff};
   assign col_ext  = {1'b0, column_ff};
   assign sum_code = col_ext + {8'd0, byte_val};
   assign sum_pend = col_ext + {8'd0, pending_ff};
   assign rem      = (column_ff < length_ff) ? (length_ff - column_ff) : 15'd0;

   // Header test for a new-format line
   assign new_header = (phase_ff == rgbe_pkg::PH_FIRST)
                    && (length_ff >= rgbe_pkg::MIN_NEW_LENGTH)
                    && (32'(length_ff) <= MAX_LINE_LENGTH)
                    && (r_byte == rgbe_pkg::HDR_BYTE)
                    && (g_byte == rgbe_pkg::HDR_BYTE)
                    && !b_byte[7];

   // Old-format repeat count: scale by shift, clamp to the columns left
   always_comb begin
      unique case (shift_ff)
         2'd0:    over = {8'd0, byte_val} > {1'b0, rem};
         2'd1:    over = {byte_val, 8'd0} > {1'b0, rem};
         default: over = (byte_val != 8'd0);
      endcase
      if (over) begin
         rep_count = rem;
      end else if (shift_ff == 2'd1) begin
         rep_count = {byte_val[6:0], 8'd0};
      end else begin
         rep_count = {7'd0, byte_val};
      end
   end

   assign fail_ch = ((phase_ff == rgbe_pkg::PH_CODE) || (phase_ff == rgbe_pkg::PH_RUNVAL)
                  || (phase_ff == rgbe_pkg::PH_LITERAL)) ? {1'b0, chan_ff}
                                                        : rgbe_pkg::CH_PIXEL;
   assign wp_sum = col_ext + {1'b0, wp_count};
   assign cr_sum = col_ext + {8'd0, cr_count};

   // Next state and result for one step
   always_comb begin
      phase_in    = phase_ff;
      length_in   = length_ff;
      column_in   = column_ff;
      chan_in     = chan_ff;
      gathered_in = gathered_ff;
      pos_in      = pos_ff;
      prev_in     = prev_ff;
      pending_in  = pending_ff;
      shift_in    = shift_ff;
      fail_en     = 1'b0;
      fail_code   = rgbe_pkg::ERR_NONE;
      wp_en       = 1'b0;
      wp_count    = 15'd0;
      wp_px       = 32'd0;
      cr_en       = 1'b0;
      cr_count    = 8'd0;
      cr_val      = 8'd0;
      restart     = 1'b0;
      res_valid   = 1'b0;
      res         = '0;

      // Decide what this byte does
      if (step && (length_ff != 15'd0)) begin
         if (item.stream_ended) begin
            fail_en   = 1'b1;
            fail_code = rgbe_pkg::ERR_EOS;
         end else begin
            unique case (phase_ff)
               rgbe_pkg::PH_FIRST, rgbe_pkg::PH_OLD: begin
                  if (pos_ff != 2'd3) begin
                     // gather one more byte of the group
                     case (pos_ff)
                        2'd0:    gathered_in[7:0]   = byte_val;
                        2'd1:    gathered_in[15:8]  = byte_val;
                        default: gathered_in[23:16] = byte_val;
                     endcase
                     pos_in = pos_ff + 2'd1;
                  end else begin
                     gathered_in = 24'd0;
                     pos_in      = 2'd0;
                     if (new_header) begin
                        if ({b_byte[6:0], byte_val} != length_ff) begin
                           fail_en   = 1'b1;
                           fail_code = rgbe_pkg::ERR_LENGTH;
                        end else begin
                           phase_in  = rgbe_pkg::PH_CODE;
                           column_in = 15'd0;
                           chan_in   = 2'd0;
                        end
                     end else begin
                        phase_in = rgbe_pkg::PH_OLD;
                        if ((r_byte == rgbe_pkg::REP_BYTE) && (g_byte == rgbe_pkg::REP_BYTE)
                            && (b_byte == rgbe_pkg::REP_BYTE)) begin
                           // repeat marker: copy previous pixel, grow shift
                           shift_in = (shift_ff == rgbe_pkg::SHIFT_MAX) ? rgbe_pkg::SHIFT_MAX
                                                                        : shift_ff + 2'd1;
                           if (byte_val != 8'd0) begin
                              wp_en    = 1'b1;
                              wp_count = rep_count;
                              wp_px    = prev_ff;
                           end
                        end else begin
                           prev_in  = px;
                           shift_in = 2'd0;
                           wp_en    = 1'b1;
                           wp_count = 15'd1;
                           wp_px    = px;
                        end
                     end
                  end
               end
               rgbe_pkg::PH_CODE: begin
                  if (byte_val > rgbe_pkg::RUN_LIMIT) begin
                     pending_in = {1'b0, byte_val[6:0]};
                     phase_in   = rgbe_pkg::PH_RUNVAL;
                  end else if (sum_code > {1'b0, length_ff}) begin
                     fail_en   = 1'b1;
                     fail_code = rgbe_pkg::ERR_OVERRUN;
                  end else if (byte_val != 8'd0) begin
                     pending_in = byte_val;
                     phase_in   = rgbe_pkg::PH_LITERAL;
                  end
               end
               rgbe_pkg::PH_RUNVAL: begin
                  if (sum_pend > {1'b0, length_ff}) begin
                     fail_en   = 1'b1;
                     fail_code = rgbe_pkg::ERR_OVERRUN;
                  end else begin
                     pending_in = 8'd0;
                     phase_in   = rgbe_pkg::PH_CODE;
                     cr_en      = 1'b1;
                     cr_count   = pending_ff;
                     cr_val     = byte_val;
                  end
               end
               rgbe_pkg::PH_LITERAL: begin
                  pending_in = pending_ff - 8'd1;
                  phase_in   = (pending_ff != 8'd1) ? rgbe_pkg::PH_LITERAL : rgbe_pkg::PH_CODE;
                  cr_en      = 1'b1;
                  cr_count   = 8'd1;
                  cr_val     = byte_val;
               end
               default: begin
                  restart = 1'b1;
               end
            endcase
         end
      end

      // Whole-pixel run
      if (wp_en) begin
         column_in          = wp_sum[14:0];
         res_valid          = 1'b1;
         res.run_start      = column_ff;
         res.run_count      = wp_count;
         res.channel        = rgbe_pkg::CH_PIXEL;
         res.red_value      = wp_px[7:0];
         res.green_value    = wp_px[15:8];
         res.blue_value     = wp_px[23:16];
         res.exponent_value = wp_px[31:24];
         res.error_code     = rgbe_pkg::ERR_NONE;
         if (wp_sum >= {1'b0, length_ff}) begin
            res.line_done = 1'b1;
            restart       = 1'b1;
         end
      end

      // One-channel run
      if (cr_en) begin
         column_in      = cr_sum[14:0];
         res_valid      = 1'b1;
         res.run_start  = column_ff;
         res.run_count  = {7'd0, cr_count};
         res.channel    = {1'b0, chan_ff};
         res.error_code = rgbe_pkg::ERR_NONE;
         case (chan_ff)
            2'd0:    res.red_value      = cr_val;
            2'd1:    res.green_value    = cr_val;
            2'd2:    res.blue_value     = cr_val;
            default: res.exponent_value = cr_val;
         endcase
         if (cr_sum >= {1'b0, length_ff}) begin
            // channel plane complete: keep its last byte, move to next plane
            prev_in[{chan_ff, 3'b000} +: 8] = cr_val;
            column_in = 15'd0;
            if (chan_ff == 2'd3) begin
               res.line_done = 1'b1;
               restart       = 1'b1;
            end else begin
               chan_in = chan_ff + 2'd1;
            end
         end
      end

      // Status result
      if (fail_en) begin
         res_valid      = 1'b1;
         res            = '0;
         res.run_start  = column_ff;
         res.channel    = fail_ch;
         res.error_code = fail_code;
         restart        = 1'b1;
      end

      // Register write: new length, fresh line
      if (csr_write) begin
         length_in = csr_length;
         restart   = 1'b1;
      end

      // Start afresh on the next line
      if (restart) begin
         phase_in    = rgbe_pkg::PH_FIRST;
         column_in   = 15'd0;
         chan_in     = 2'd0;
         gathered_in = 24'd0;
         pos_in      = 2'd0;
         pending_in  = 8'd0;
         shift_in    = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= rgbe_pkg::PH_FIRST;
         length_ff   <= rgbe_pkg::RESET_LENGTH;
         column_ff   <= 15'd0;
         chan_ff     <= 2'd0;
         gathered_ff <= 24'd0;
         pos_ff      <= 2'd0;
         prev_ff     <= 32'd0;
         pending_ff  <= 8'd0;
         shift_ff    <= 2'd0;
      end else begin
         phase_ff    <= phase_in;
         length_ff   <= length_in;
         column_ff   <= column_in;
         chan_ff     <= chan_in;
         gathered_ff <= gathered_in;
         pos_ff      <= pos_in;
         prev_ff     <= prev_in;
         pending_ff  <= pending_in;
         shift_ff    <= shift_in;
      end
   end

endmodule

@@ design/rgbe_out_reg.sv @@
// ----------------------------------------------------------------------------
// rgbe_out_reg
// Result register: holds one response until the consumer takes it.
// ----------------------------------------------------------------------------
module rgbe_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  rgbe_pkg::rsp_type load_data,
   output logic              can_take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rgbe_pkg::rsp_type rsp_data
);

   logic              valid_ff;
   logic              valid_in;
   rgbe_pkg::rsp_type data_ff;

   // Room when empty or when the held response leaves this cycle
   assign can_take = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture a new response
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ design/rgbe_scanline_rle_decoder.sv @@
// ----------------------------------------------------------------------------
// rgbe_scanline_rle_decoder
// Decodes RGBE scanlines (old and run-length formats) one byte per request
// and reports decoded spans as runs.
//
//   port group  direction  carries
//   req_*       in         data_byte, stream_ended
//   rsp_*       out        run_start, run_count, channel, four bytes,
//                          line_done, error_code
//   csr_*       in         scanline_length (15 bits)
//
// One request per cycle while responses are taken. A request is held in the
// input register; the decode step is combinational from there into the
// result register, which presents the response. A response waiting on
// rsp_ready stalls the decode step and, through it, req_ready. Synchronous
// reset sets the length to 1024 and starts a fresh line; no clearing pass.
// csr_ready is high while no request waits in the input register.
// ----------------------------------------------------------------------------
module rgbe_scanline_rle_decoder #(
   parameter int MAX_LINE_LENGTH = 32767
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_ended,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [14:0] rsp_run_start,
   output logic [14:0] rsp_run_count,
   output logic [2:0]  rsp_channel,
   output logic [7:0]  rsp_red_value,
   output logic [7:0]  rsp_green_value,
   output logic [7:0]  rsp_blue_value,
   output logic [7:0]  rsp_exponent_value,
   output logic        rsp_line_done,
   output logic [1:0]  rsp_error_code,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [14:0] csr_data
);

   rgbe_pkg::req_type req_item;
   rgbe_pkg::req_type held_item;
   rgbe_pkg::rsp_type step_rsp;
   rgbe_pkg::rsp_type rsp_q;
   logic              held_valid;
   logic              out_room;
   logic              fire;
   logic              step_valid;
   logic              csr_write;

   assign req_item.data_byte    = req_data_byte;
   assign req_item.stream_ended = req_stream_ended;

   // Decode step runs when a request is held and the result register has room
   assign fire      = held_valid && out_room;
   assign csr_ready = !held_valid;
   assign csr_write = csr_valid && csr_ready;

   rgbe_in_reg u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_item),
      .take       (fire),
      .held_valid (held_valid),
      .held_data  (held_item)
   );

   rgbe_decode #(
      .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_length (csr_data),
      .step       (fire),
      .item       (held_item),
      .res_valid  (step_valid),
      .res        (step_rsp)
   );

   rgbe_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && step_valid),
      .load_data (step_rsp),
      .can_take  (out_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_q)
   );

   assign rsp_run_start      = rsp_q.run_start;
   assign rsp_run_count      = rsp_q.run_count;
   assign rsp_channel        = rsp_q.channel;
   assign rsp_red_value      = rsp_q.red_value;
   assign rsp_green_value    = rsp_q.green_value;
   assign rsp_blue_value     = rsp_q.blue_value;
   assign rsp_exponent_value = rsp_q.exponent_value;
   assign rsp_line_done      = rsp_q.line_done;
   assign rsp_error_code     = rsp_q.error_code;

   // A response only appears after a decode step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(fire))
      else $error("response without a decode step");

   // Configuration never lands on a decode step
   assert property (@(posedge clock) disable iff (reset)
      csr_write |-> !fire)
      else $error("configuration write during a decode step");

   // A completed line carries no error
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_done) |-> (rsp_error_code == rgbe_pkg::ERR_NONE))
      else $error("line done with an error");

   // Status responses cover no columns
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_error_code != rgbe_pkg::ERR_NONE)) |-> (rsp_run_count == 15'd0))
      else $error("error response with a nonzero count");

endmodule

@@ bench/tb_rgbe_scanline_rle_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgbe_scanline_rle_decoder
// Self-checking bench for the RGBE scanline run-length decoder. Byte requests
// go in through a valid/ready channel, and a built-in line decoder predicts
// every run. Each accepted response is checked field by field against the
// oldest prediction. Directed cases cover the format corners. Random lines
// in both formats follow, mixed with faults and noise, over several line
// lengths, at first under random back-pressure.
// ----------------------------------------------------------------------------
module tb_rgbe_scanline_rle_decoder;

   localparam int LINE_LIMIT = 32767;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_stream_ended;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [14:0] rsp_run_start;
   logic [14:0] rsp_run_count;
   logic [2:0]  rsp_channel;
   logic [7:0]  rsp_red_value;
   logic [7:0]  rsp_green_value;
   logic [7:0]  rsp_blue_value;
   logic [7:0]  rsp_exponent_value;
   logic        rsp_line_done;
   logic [1:0]  rsp_error_code;
   logic        csr_valid;
   logic        csr_ready;
   logic [14:0] csr_data;

   // Predicted runs, oldest first
   rgbe_pkg::rsp_type expected_runs[$];
   int unsigned mismatch_total = 0;
   int unsigned request_total = 0;

   // Idle control shared by the request driver and the response stall process
   bit          idle_on = 1'b0;
   int unsigned idle_pct = 0;

   // Line decoder state of the predictor
   int unsigned         pred_length;
   rgbe_pkg::phase_type line_phase;
   int unsigned         line_col;
   int unsigned         plane_idx;
   logic [23:0]         group_bytes;
   int unsigned         group_pos;
   logic [31:0]         last_pixel;
   int unsigned         code_count;
   int unsigned         marker_shift;

   rgbe_scanline_rle_decoder #(
      .MAX_LINE_LENGTH(LINE_LIMIT)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_stream_ended   (req_stream_ended),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_run_start      (rsp_run_start),
      .rsp_run_count      (rsp_run_count),
      .rsp_channel        (rsp_channel),
      .rsp_red_value      (rsp_red_value),
      .rsp_green_value    (rsp_green_value),
      .rsp_blue_value     (rsp_blue_value),
      .rsp_exponent_value (rsp_exponent_value),
      .rsp_line_done      (rsp_line_done),
      .rsp_error_code     (rsp_error_code),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   // ------------------------------------------------------------------
   // Line decoder prediction
   // ------------------------------------------------------------------

   // Drop any partial line and start afresh
   function automatic void restart_decode();
      line_phase   = rgbe_pkg::PH_FIRST;
      line_col     = 0;
      plane_idx    = 0;
      group_bytes  = '0;
      group_pos    = 0;
      code_count   = 0;
      marker_shift = 0;
   endfunction

   function automatic rgbe_pkg::rsp_type form_run(input int unsigned start,
                                                  input int unsigned count,
                                                  input logic [2:0] chan,
                                                  input logic [31:0] pixel,
                                                  input bit done, input logic [1:0] err);
      rgbe_pkg::rsp_type run;
      run.run_start      = start[14:0];
      run.run_count      = count[14:0];
      run.channel        = chan;
      run.red_value      = pixel[7:0];
      run.green_value    = pixel[15:8];
      run.blue_value     = pixel[23:16];
      run.exponent_value = pixel[31:24];
      run.line_done      = done;
      run.error_code     = err;
      return run;
   endfunction

   // Status result at the current column, then restart
   function automatic rgbe_pkg::rsp_type abort_line(input logic [1:0] err);
      rgbe_pkg::rsp_type run;
      logic [2:0]        chan;
      chan = (line_phase >= rgbe_pkg::PH_CODE) ? 3'(plane_idx) : rgbe_pkg::CH_PIXEL;
      run = form_run(line_col, 0, chan, '0, 1'b0, err);
      restart_decode();
      return run;
   endfunction

   // One-channel run of a new-format line
   function automatic rgbe_pkg::rsp_type plane_run(input int unsigned count,
                                                   input logic [7:0] value);
      int unsigned start;
      int unsigned chan;
      bit          done;
      start = line_col;
      chan  = plane_idx & 3;
      done  = 1'b0;
      line_col += count;
      if (line_col >= pred_length) begin
         last_pixel[8*chan +: 8] = value;
         line_col  = 0;
         plane_idx = chan + 1;
         if (plane_idx >= 4) begin
            done = 1'b1;
            restart_decode();
         end
      end
      return form_run(start, count, 3'(chan), 32'(value) << (8 * chan), done,
                      rgbe_pkg::ERR_NONE);
   endfunction

   // Whole-pixel run of an old-format line
   function automatic rgbe_pkg::rsp_type pixel_run(input int unsigned count,
                                                   input logic [31:0] pixel);
      int unsigned start;
      bit          done;
      start = line_col;
      done  = 1'b0;
      line_col += count;
      if (line_col >= pred_length) begin
         done = 1'b1;
         restart_decode();
      end
      return form_run(start, count, rgbe_pkg::CH_PIXEL, pixel, done, rgbe_pkg::ERR_NONE);
   endfunction

   // Advance the predicted decoder by one request; 1 when a run results
   function automatic bit predict_decode(input logic [7:0] value, input logic ended,
                                         output rgbe_pkg::rsp_type run);
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [31:0] pixel;
      int unsigned count;
      int unsigned left;
      run = '0;
      if (pred_length == 0) return 1'b0;
      if (ended) begin
         run = abort_line(rgbe_pkg::ERR_EOS);
         return 1'b1;
      end
      case (line_phase)
         rgbe_pkg::PH_FIRST, rgbe_pkg::PH_OLD: begin
            if (group_pos < 3) begin
               group_bytes[8*group_pos +: 8] = value;
               group_pos++;
               return 1'b0;
            end
            red   = group_bytes[7:0];
            green = group_bytes[15:8];
            blue  = group_bytes[23:16];
            pixel = {value, group_bytes};
            group_bytes = '0;
            group_pos   = 0;
            // new-format header
            if (line_phase == rgbe_pkg::PH_FIRST && pred_length >= 8 &&
                pred_length <= LINE_LIMIT && red == rgbe_pkg::HDR_BYTE &&
                green == rgbe_pkg::HDR_BYTE && !blue[7]) begin
               if (int'({blue, value}) != pred_length) begin
                  run = abort_line(rgbe_pkg::ERR_LENGTH);
                  return 1'b1;
               end
               line_phase = rgbe_pkg::PH_CODE;
               line_col   = 0;
               plane_idx  = 0;
               return 1'b0;
            end
            line_phase = rgbe_pkg::PH_OLD;
            left = (line_col < pred_length) ? pred_length - line_col : 0;
            // repeat marker: count scaled by the running shift
            if (red == rgbe_pkg::REP_BYTE && green == rgbe_pkg::REP_BYTE &&
                blue == rgbe_pkg::REP_BYTE) begin
               count = 32'(value) << ((marker_shift > 24) ? 24 : marker_shift);
               marker_shift = (marker_shift >= 24) ? 24 : marker_shift + 8;
               if (count == 0) return 1'b0;
               if (count > left) count = left;
               run = pixel_run(count, last_pixel);
               return 1'b1;
            end
            last_pixel   = pixel;
            marker_shift = 0;
            run = pixel_run(1, pixel);
            return 1'b1;
         end
         rgbe_pkg::PH_CODE: begin
            if (value > rgbe_pkg::RUN_LIMIT) begin
               code_count = value & 8'h7f;
               line_phase = rgbe_pkg::PH_RUNVAL;
               return 1'b0;
            end
            if (line_col + value > pred_length) begin
               run = abort_line(rgbe_pkg::ERR_OVERRUN);
               return 1'b1;
            end
            if (value == 0) return 1'b0;
            code_count = value;
            line_phase = rgbe_pkg::PH_LITERAL;
            return 1'b0;
         end
         rgbe_pkg::PH_RUNVAL: begin
            count = code_count & 8'hff;
            if (line_col + count > pred_length) begin
               run = abort_line(rgbe_pkg::ERR_OVERRUN);
               return 1'b1;
            end
            code_count = 0;
            line_phase = rgbe_pkg::PH_CODE;
            run = plane_run(count, value);
            return 1'b1;
         end
         rgbe_pkg::PH_LITERAL: begin
            code_count = (code_count - 1) & 8'hff;
            line_phase = (code_count != 0) ? rgbe_pkg::PH_LITERAL : rgbe_pkg::PH_CODE;
            run = plane_run(1, value);
            return 1'b1;
         end
         default: begin
            restart_decode();
            return 1'b0;
         end
      endcase
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      if (mismatch_total < 100) $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_total++;
   endtask

   task automatic check_field(input string name, input int unsigned seen,
                              input int unsigned due);
      if (seen != due) report_mismatch($sformatf("%s is %0d, predicted %0d", name, seen, due));
   endtask

   // Predict on each accepted request, compare each accepted response
   always @(posedge clock) begin : decode_monitor
      rgbe_pkg::rsp_type due;
      if (reset) begin
         pred_length = rgbe_pkg::RESET_LENGTH;
         last_pixel  = '0;
         restart_decode();
      end else begin
         if (csr_valid && csr_ready) begin
            pred_length = csr_data;
            restart_decode();
         end
         if (req_valid && req_ready) begin
            if (predict_decode(req_data_byte, req_stream_ended, due))
               expected_runs.push_back(due);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_runs.size() == 0) begin
               report_mismatch("response arrived with no run outstanding");
            end else begin
               due = expected_runs.pop_front();
               check_field("run_start", rsp_run_start, due.run_start);
               check_field("run_count", rsp_run_count, due.run_count);
               check_field("channel", rsp_channel, due.channel);
               check_field("red_value", rsp_red_value, due.red_value);
               check_field("green_value", rsp_green_value, due.green_value);
               check_field("blue_value", rsp_blue_value, due.blue_value);
               check_field("exponent_value", rsp_exponent_value, due.exponent_value);
               check_field("line_done", rsp_line_done, due.line_done);
               check_field("error_code", rsp_error_code, due.error_code);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Clock, response stalls, run limit
   // ------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the response side in random bursts
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 99) < idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Request driving (called at a falling edge, returns at one)
   // ------------------------------------------------------------------

   task automatic send_req(input logic [7:0] value, input logic ended);
      if (idle_on && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= value;
      req_stream_ended <= ended;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      request_total++;
   endtask

   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic [7:0] expo);
      send_req(red, 1'b0);
      send_req(green, 1'b0);
      send_req(blue, 1'b0);
      send_req(expo, 1'b0);
   endtask

   // Hold requests until every run is back and the decode step is empty
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_runs.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_length(input int unsigned len);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= 15'(len);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Random line generators
   // ------------------------------------------------------------------

   // New-format line, sometimes broken by a fault; long lines are cut short
   task automatic send_new_line(input int unsigned len);
      int unsigned left;
      int unsigned n;
      int unsigned codes;
      int unsigned fault;
      int unsigned lit_cap;
      logic [7:0]  lo;
      lo = 8'(len);
      if ($urandom_range(0, 14) == 0) lo = lo ^ 8'($urandom_range(1, 255));
      send_pixel(rgbe_pkg::HDR_BYTE, rgbe_pkg::HDR_BYTE, 8'(len >> 8), lo);
      if (line_phase != rgbe_pkg::PH_CODE) return;
      codes = 0;
      // keep literal groups short on long lines
      lit_cap = (len > 64) ? 16 : 128;
      for (int plane = 0; plane < 4; plane++) begin
         left = len;
         while (left > 0) begin
            if (codes >= 12 && len > 64) begin
               send_req(8'($urandom), 1'b1);
               return;
            end
            // inject a fault: early end, run overrun or literal overrun
            if ($urandom_range(0, 39) == 0) begin
               fault = $urandom_range(0, 2);
               if (fault == 1 && left < 127) begin
                  send_req(8'(128 + $urandom_range(left + 1, 127)), 1'b0);
                  send_req(8'($urandom), 1'b0);
               end else if (fault == 2 && left < 128) begin
                  send_req(8'($urandom_range(left + 1, 128)), 1'b0);
               end else begin
                  send_req(8'($urandom), 1'b1);
               end
               return;
            end
            if ($urandom_range(0, 9) == 0) send_req(8'h00, 1'b0);
            if ($urandom_range(0, 1) == 1) begin
               n = $urandom_range(1, (left < 127) ? left : 127);
               send_req(8'(128 + n), 1'b0);
               send_req(8'($urandom), 1'b0);
            end else begin
               n = $urandom_range(1, (left < lit_cap) ? left : lit_cap);
               send_req(8'(n), 1'b0);
               repeat (n) send_req(8'($urandom), 1'b0);
            end
            left -= n;
            codes++;
         end
      end
   endtask

   // Old-format line of literal pixels and repeat chains
   task automatic send_old_line();
      int unsigned groups;
      int unsigned chain;
      logic [7:0]  count;
      groups = 0;
      do begin
         if ($urandom_range(0, 3) == 0) begin
            chain = $urandom_range(1, 3);
            while (chain > 0 && !(groups > 0 && line_phase == rgbe_pkg::PH_FIRST)) begin
               case ($urandom_range(0, 11))
                  0, 1:    count = 8'h00;
                  2:       count = 8'hff;
                  default: count = 8'($urandom_range(1, 3));
               endcase
               send_pixel(rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, count);
               chain--;
               groups++;
            end
         end else begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            groups++;
         end
      end while (line_phase != rgbe_pkg::PH_FIRST && groups < 24);
      // finish with a saturated repeat that clamps to the columns left
      if (line_phase == rgbe_pkg::PH_OLD) begin
         repeat (3)
            send_pixel(rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, 8'h00);
         send_pixel(rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, 8'h01);
      end
      if (line_phase != rgbe_pkg::PH_FIRST) send_req(8'($urandom), 1'b1);
   endtask

   // Random bytes, then an end of stream to resynchronize
   task automatic send_noise();
      repeat ($urandom_range(3, 16))
         send_req(8'($urandom), $urandom_range(0, 15) == 0);
      send_req(8'($urandom), 1'b1);
   endtask

   task automatic run_random_traffic(input int unsigned quota, input bit with_idle);
      int unsigned goal;
      int unsigned len;
      int unsigned kind;
      int unsigned setting;
      int unsigned lines;
      goal = request_total + quota;
      setting = 0;
      while (request_total < goal) begin
         if (setting == 0) len = LINE_LIMIT;
         else if (setting == 1) len = 1;
         else begin
            case ($urandom_range(0, 11))
               0:       len = 1;
               1:       len = LINE_LIMIT;
               2:       len = 8;
               default: len = $urandom_range(2, 48);
            endcase
         end
         write_length(len);
         setting++;
         idle_on = with_idle;
         case ($urandom_range(0, 3))
            0:       idle_pct = 0;
            1:       idle_pct = 4;
            2:       idle_pct = 12;
            default: idle_pct = 25;
         endcase
         // stop at the line where the quota is reached
         lines = $urandom_range(2, 5);
         for (int i = 0; i < lines && request_total < goal; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6 && len >= 8) send_new_line(len);
            else if (kind < 9) send_old_line();
            else send_noise();
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Length from reset, stream end anywhere, header length mismatch
   task automatic test_reset_defaults();
      send_pixel(rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, 8'd3);
      send_req(8'h00, 1'b1);
      send_req(8'hff, 1'b1);
      send_pixel(rgbe_pkg::HDR_BYTE, rgbe_pkg::HDR_BYTE, 8'h04, 8'h00);
      send_req(8'h5a, 1'b1);
      send_pixel(rgbe_pkg::HDR_BYTE, rgbe_pkg::HDR_BYTE, 8'h04, 8'h01);
   endtask

   // Empty literal, run overrun at its value, literal overrun at its code
   task automatic test_new_format_edges();
      write_length(8);
      send_pixel(rgbe_pkg::HDR_BYTE, rgbe_pkg::HDR_BYTE, 8'h00, 8'h08);
      send_req(8'h00, 1'b0);
      send_req(8'h89, 1'b0);
      send_req(8'h00, 1'b0);
      send_pixel(rgbe_pkg::HDR_BYTE, rgbe_pkg::HDR_BYTE, 8'h00, 8'h08);
      send_req(8'h88, 1'b0);
      send_req(8'hff, 1'b0);
      send_req(rgbe_pkg::RUN_LIMIT, 1'b0);
   endtask

   // Zero-count marker, clamped repeat, repeat at line start, restart on write
   task automatic test_old_format_edges();
      write_length(5);
      send_pixel(8'hff, 8'hff, 8'hff, 8'hff);
      send_pixel(rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, 8'h00);
      send_pixel(rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, 8'hff);
      send_pixel(rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, 8'h02);
      send_req(rgbe_pkg::HDR_BYTE, 1'b0);
      send_req(rgbe_pkg::HDR_BYTE, 1'b0);
      write_length(1);
      send_pixel(rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, rgbe_pkg::REP_BYTE, 8'h01);
   endtask

   task automatic test_random_lines();
      run_random_traffic(300, 1'b1);
   endtask

   task automatic test_steady_tail();
      idle_on = 1'b0;
      run_random_traffic(50, 1'b0);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_stream_ended = 1'b0;
      csr_valid        = 1'b0;
      csr_data         = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_new_format_edges();
      test_old_format_edges();
      test_random_lines();
      test_steady_tail();

      wait_drained();
      repeat (8) @(negedge clock);
      if (mismatch_total == 0 && expected_runs.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/rgbe_pkg.sv
design/rgbe_in_reg.sv
design/rgbe_decode.sv
design/rgbe_out_reg.sv
design/rgbe_scanline_rle_decoder.sv
bench/tb_rgbe_scanline_rle_decoder.sv
